@@ hw/rtl/rgb_to_hls_converter_unit_macros.svh @@
// Assertion macros used by rgb_hls_checker, the verification file of the RGB to HLS converter.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef RGB_TO_HLS_CONVERTER_UNIT_MACROS_SVH
`define RGB_TO_HLS_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RHC_CHECK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RHC_CHECK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rgb_hls_pkg.sv @@
// Constants, codes and types of the RGB to HLS converter.
// Depends on nothing; every other file of the block but rgb_hls_div and the macros header imports it.
package rgb_hls_pkg;

    localparam int COMP_W      = 16;
    localparam int HUE_FRAC    = 6;
    localparam int HUE_W       = 16;
    localparam int LIGHT_W     = 16;
    localparam int SAT_W       = 17;
    localparam int FULL_SCALE  = 1 << COMP_W;

    localparam int DEG_60      = 60 << HUE_FRAC;
    localparam int DEG_120     = 120 << HUE_FRAC;
    localparam int DEG_240     = 240 << HUE_FRAC;
    localparam int DEG_360     = 360 << HUE_FRAC;

    localparam int HUE_K_W     = $clog2(DEG_60 + 1);
    localparam logic signed [HUE_K_W:0] HUE_K = (HUE_K_W + 1)'(DEG_60);

    localparam int DIFF_W      = COMP_W + 1;
    localparam int PROD_W      = DIFF_W + HUE_K_W + 1;
    localparam int HUE_N_W     = PROD_W + 1;
    localparam int HUE_A_W     = PROD_W;
    localparam int HUE_D_W     = COMP_W + 1;
    localparam int SAT_N_W     = 2 * COMP_W + 1;
    localparam int SAT_D_W     = COMP_W + 2;
    localparam int DIV_STAGES  = COMP_W + 1;
    localparam int HUE_INT_W   = DIV_STAGES + 3;

    localparam int QUEUE_DEPTH = 4;

    typedef logic [1:0] t_sector;
    localparam t_sector SEC_NONE  = 2'd0;
    localparam t_sector SEC_RED   = 2'd1;
    localparam t_sector SEC_GREEN = 2'd2;
    localparam t_sector SEC_BLUE  = 2'd3;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [COMP_W-1:0]        span;
        logic [COMP_W:0]          den;
        logic [LIGHT_W-1:0]       light;
        t_sector                  sector;
        logic                     hue_on;
        logic                     sat_on;
    } t_item;

    typedef struct packed {
        logic [LIGHT_W-1:0] light;
        t_sector            sector;
        logic               hue_on;
        logic               sat_on;
        logic               neg;
        logic               ovf;
    } t_side;

endpackage

@@ hw/rtl/rgb_hls_if.sv @@
// Handshake channels of the RGB to HLS converter: pixel, result and configuration.
// Depends on rgb_hls_pkg for the field widths.
interface rgb_hls_pix_if;
    import rgb_hls_pkg::*;
    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [COMP_W-1:0] max_component;
    logic [COMP_W-1:0] min_component;
    modport source (output valid, red, green, blue, max_component, min_component,
                    input ready);
    modport sink (input valid, red, green, blue, max_component, min_component,
                  output ready);
endinterface

interface rgb_hls_res_if;
    import rgb_hls_pkg::*;
    logic                     valid;
    logic                     ready;
    logic signed [HUE_W-1:0]  hue;
    logic [LIGHT_W-1:0]       lightness;
    logic [SAT_W-1:0]         saturation;
    modport source (output valid, hue, lightness, saturation, input ready);
    modport sink (input valid, hue, lightness, saturation, output ready);
endinterface

interface rgb_hls_cfg_if;
    logic valid;
    logic ready;
    logic normalize_hue;
    modport source (output valid, normalize_hue, input ready);
    modport sink (input valid, normalize_hue, output ready);
endinterface

@@ hw/rtl/rgb_to_hls_converter_unit.sv @@
// Converts one RGB pixel per cycle, while its queue has room, into hue, lightness and
// saturation. A pixel gives red, green, blue and the caller's maximum and minimum of
// them as Q0.16 fractions; the result is hue in degrees with six fraction bits,
// lightness in Q0.16 and saturation in Q1.16. The block returns results in order; the
// two dividers produce one quotient bit per stage over 17 stages. A four-entry queue
// lets the input keep flowing while the output is stalled. The normalize_hue register
// (reset to one) adds 360 degrees to negative hues; the configuration channel is always
// ready and should only be written while no pixel is in flight.
module rgb_to_hls_converter_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rgb_hls_cfg_if.sink   i_cfg,
    rgb_hls_pix_if.sink   i_pixel,
    rgb_hls_res_if.source o_result
);
    import rgb_hls_pkg::*;

    logic  r_normalize;
    logic  push;
    logic  full;
    logic  pop;
    logic  empty;
    t_item front_item;
    t_item head_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_normalize <= 1'b1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_normalize <= i_cfg.normalize_hue;
        end
    end

    rgb_hls_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (i_pixel),
        .i_full  (full),
        .o_push  (push),
        .o_item  (front_item)
    );

    rgb_hls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_item)
    );

    rgb_hls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_normalize (r_normalize),
        .i_head      (head_item),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_result    (o_result)
    );

endmodule

@@ hw/rtl/rgb_hls_queue.sv @@
// Short queue of classified pixels between the front and back parts.
// Depends on rgb_hls_pkg for the item type and depth.
module rgb_hls_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  rgb_hls_pkg::t_item  i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output rgb_hls_pkg::t_item  o_head
);
    import rgb_hls_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ hw/rtl/rgb_hls_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing; the dividend must be below the divisor shifted by the quotient width.
module rgb_hls_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 17,
    parameter int QUO_W = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    localparam int REM_W = DEN_W + QUO_W;

    logic [REM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int BIT = QUO_W - 1 - s;
        logic [REM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [REM_W:0]   trial;

        if (s == 0) begin : g_first
            assign rem_in = REM_W'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = {1'b0, rem_in} - ((REM_W + 1)'(den_in) << BIT);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= den_in;
                if (trial[REM_W]) begin
                    r_rem[s] <= rem_in;
                    r_quo[s] <= quo_in;
                end else begin
                    r_rem[s] <= trial[REM_W-1:0];
                    r_quo[s] <= quo_in | (QUO_W'(1) << BIT);
                end
            end
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

@@ hw/rtl/rgb_hls_front.sv @@
// Front part: accepts pixels and classifies them into sector, differences and flags.
// Depends on rgb_hls_pkg and the pixel channel interface.
module rgb_hls_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rgb_hls_pix_if.sink        i_pixel,
    input  logic               i_full,
    output logic               o_push,
    output rgb_hls_pkg::t_item o_item
);
    import rgb_hls_pkg::*;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [COMP_W:0]   sum;
    logic [COMP_W+1:0] den_wide;
    logic              max_nz;
    logic              range_pos;

    assign i_pixel.ready = !r_valid || !i_full;
    assign o_push        = r_valid;
    assign o_item        = r_item;

    always_comb begin
        sum       = {1'b0, i_pixel.max_component} + {1'b0, i_pixel.min_component};
        den_wide  = {1'b1, {(COMP_W + 1){1'b0}}} - {1'b0, sum};
        max_nz    = (i_pixel.max_component != '0);
        range_pos = (i_pixel.max_component > i_pixel.min_component);

        n_item.span  = i_pixel.max_component - i_pixel.min_component;
        n_item.den   = sum[COMP_W] ? den_wide[COMP_W:0] : sum;
        n_item.light = max_nz ? LIGHT_W'(sum[COMP_W:1]) : '0;

        if (i_pixel.max_component == i_pixel.red) begin
            n_item.sector = SEC_RED;
        end else if (i_pixel.max_component == i_pixel.green) begin
            n_item.sector = SEC_GREEN;
        end else if (i_pixel.max_component == i_pixel.blue) begin
            n_item.sector = SEC_BLUE;
        end else begin
            n_item.sector = SEC_NONE;
        end

        unique case (n_item.sector)
            SEC_RED: begin
                n_item.diff = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
            end
            SEC_GREEN: begin
                n_item.diff = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
            end
            SEC_BLUE: begin
                n_item.diff = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
            end
            default: begin
                n_item.diff = '0;
            end
        endcase

        n_item.sat_on = max_nz && range_pos;
        n_item.hue_on = max_nz && range_pos && (n_item.sector != SEC_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_pixel.ready) begin
            r_valid <= i_pixel.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pixel.valid && i_pixel.ready) begin
            r_item <= n_item;
        end
    end

endmodule

@@ hw/rtl/rgb_hls_back.sv @@
// Back part: hue and saturation divisions, offsets, normalising, clamping and output register.
// Depends on rgb_hls_pkg, rgb_hls_div and the result channel interface.
module rgb_hls_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_normalize,
    input  rgb_hls_pkg::t_item i_head,
    input  logic               i_empty,
    output logic               o_pop,
    rgb_hls_res_if.source      o_result
);
    import rgb_hls_pkg::*;

    localparam logic signed [HUE_INT_W-1:0] HUE_LO  = -HUE_INT_W'(DEG_60);
    localparam logic signed [HUE_INT_W-1:0] HUE_HI  = HUE_INT_W'(DEG_360);
    localparam logic signed [HUE_INT_W-1:0] OFF_120 = HUE_INT_W'(DEG_120);
    localparam logic signed [HUE_INT_W-1:0] OFF_240 = HUE_INT_W'(DEG_240);
    localparam logic [SAT_W-1:0]            SAT_ONE = SAT_W'(FULL_SCALE);

    logic                            en;
    logic signed [PROD_W-1:0]        prod;
    logic                            r_m1_v;
    t_item                           r_m1_item;
    logic signed [PROD_W-1:0]        r_m1_prod;

    logic [HUE_N_W-1:0]              hue_n;
    logic [HUE_A_W-1:0]              hue_a;
    logic [HUE_D_W-1:0]              hue_d;
    logic                            hue_ovf;
    logic [SAT_N_W-1:0]              sat_n;
    logic [SAT_D_W-1:0]              sat_d;
    t_side                           n_side;

    logic                            r_m2_v;
    logic [HUE_A_W-1:0]              r_m2_hn;
    logic [HUE_D_W-1:0]              r_m2_hd;
    logic [SAT_N_W-1:0]              r_m2_sn;
    logic [SAT_D_W-1:0]              r_m2_sd;
    t_side                           r_m2_side;

    logic                            r_sv [DIV_STAGES];
    t_side                           r_sd [DIV_STAGES];
    logic [DIV_STAGES-1:0]           hue_quo;
    logic [DIV_STAGES-1:0]           sat_quo;

    t_side                           last;
    logic [DIV_STAGES-1:0]           q_mag;
    logic signed [HUE_INT_W-1:0]     q_s;
    logic signed [HUE_INT_W-1:0]     h1;
    logic signed [HUE_INT_W-1:0]     h2;
    logic signed [HUE_INT_W-1:0]     h3;
    logic [SAT_W-1:0]                n_sat;

    logic                            r_out_valid;
    logic signed [HUE_W-1:0]         r_hue;
    logic [LIGHT_W-1:0]              r_light;
    logic [SAT_W-1:0]                r_sat;

    assign en    = !r_out_valid || o_result.ready;
    assign o_pop = en && !i_empty;
    assign prod  = HUE_K * $signed(i_head.diff);

    always_comb begin
        hue_n   = {r_m1_prod, 1'b0} + HUE_N_W'(r_m1_item.span);
        hue_a   = hue_n[HUE_N_W-1] ? ~hue_n[HUE_A_W-1:0] : hue_n[HUE_A_W-1:0];
        hue_d   = {r_m1_item.span, 1'b0};
        hue_ovf = ((HUE_D_W + DIV_STAGES)'(hue_a) >= {hue_d, {DIV_STAGES{1'b0}}});
        sat_n   = {r_m1_item.span, {(COMP_W + 1){1'b0}}} + SAT_N_W'(r_m1_item.den);
        sat_d   = {r_m1_item.den, 1'b0};

        n_side.light  = r_m1_item.light;
        n_side.sector = r_m1_item.sector;
        n_side.hue_on = r_m1_item.hue_on;
        n_side.sat_on = r_m1_item.sat_on;
        n_side.neg    = hue_n[HUE_N_W-1];
        n_side.ovf    = hue_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
        end else if (en) begin
            r_m1_v <= !i_empty;
            r_m2_v <= r_m1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_item <= i_head;
            r_m1_prod <= prod;
            r_m2_hn   <= hue_a;
            r_m2_hd   <= hue_d;
            r_m2_sn   <= sat_n;
            r_m2_sd   <= sat_d;
            r_m2_side <= n_side;
        end
    end

    rgb_hls_div #(
        .NUM_W (HUE_A_W),
        .DEN_W (HUE_D_W),
        .QUO_W (DIV_STAGES)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_m2_hn),
        .i_den (r_m2_hd),
        .o_quo (hue_quo)
    );

    rgb_hls_div #(
        .NUM_W (SAT_N_W),
        .DEN_W (SAT_D_W),
        .QUO_W (DIV_STAGES)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_m2_sn),
        .i_den (r_m2_sd),
        .o_quo (sat_quo)
    );

    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_side
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[s] <= 1'b0;
            end else if (en) begin
                r_sv[s] <= (s == 0) ? r_m2_v : r_sv[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sd[s] <= (s == 0) ? r_m2_side : r_sd[(s == 0) ? 0 : s - 1];
            end
        end
    end

    always_comb begin
        last  = r_sd[DIV_STAGES-1];
        q_mag = last.ovf ? '1 : hue_quo;
        q_s   = last.neg ? ~{3'b000, q_mag} : {3'b000, q_mag};

        case (last.sector)
            SEC_GREEN: h1 = q_s + OFF_120;
            SEC_BLUE:  h1 = q_s + OFF_240;
            default:   h1 = q_s;
        endcase
        if (!last.hue_on) begin
            h1 = '0;
        end

        h2 = (i_normalize && (h1 < 0)) ? h1 + HUE_HI : h1;

        if (h2 < HUE_LO) begin
            h3 = HUE_LO;
        end else if (h2 > HUE_HI) begin
            h3 = HUE_HI;
        end else begin
            h3 = h2;
        end

        if (!last.sat_on) begin
            n_sat = '0;
        end else if (SAT_W'(sat_quo) > SAT_ONE) begin
            n_sat = SAT_ONE;
        end else begin
            n_sat = SAT_W'(sat_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_sv[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue   <= h3[HUE_W-1:0];
            r_light <= last.light;
            r_sat   <= n_sat;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.hue        = r_hue;
    assign o_result.lightness  = r_light;
    assign o_result.saturation = r_sat;

endmodule

@@ hw/rtl/rgb_hls_checker.sv @@
// Port-level assertions on the result channel of the RGB to HLS converter, bound to the top.
// Depends on rgb_hls_pkg and rgb_to_hls_converter_unit_macros.svh.
`include "rgb_to_hls_converter_unit_macros.svh"

module rgb_hls_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              i_ready,
    input logic signed [rgb_hls_pkg::HUE_W-1:0] i_hue,
    input logic [rgb_hls_pkg::LIGHT_W-1:0]   i_lightness,
    input logic [rgb_hls_pkg::SAT_W-1:0]     i_saturation
);
    import rgb_hls_pkg::*;

    localparam logic signed [HUE_W-1:0] HUE_LO  = -HUE_W'(DEG_60);
    localparam logic signed [HUE_W-1:0] HUE_HI  = HUE_W'(DEG_360);
    localparam logic [SAT_W-1:0]        SAT_ONE = SAT_W'(FULL_SCALE);

    `RHC_CHECK_NEXT(a_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_hue) && $stable(i_lightness) && $stable(i_saturation), "stalled result changed")
    `RHC_CHECK(a_sat_max, i_clk, i_rst_n, i_valid, i_saturation <= SAT_ONE, "saturation above one")
    `RHC_CHECK(a_hue_rng, i_clk, i_rst_n, i_valid, (i_hue >= HUE_LO) && (i_hue <= HUE_HI), "hue outside its range")
    `RHC_CHECK(a_grey_hue, i_clk, i_rst_n, i_valid && (i_saturation == '0), i_hue == '0, "grey pixel with non-zero hue")

endmodule

bind rgb_to_hls_converter_unit rgb_hls_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_hue        (o_result.hue),
    .i_lightness  (o_result.lightness),
    .i_saturation (o_result.saturation)
);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rgb_to_hls_converter_unit: directed corner pixels, then random
// pixels under bursty requests, random output stalls and changes of the hue wrap register.
// Depends on rgb_hls_pkg and the channel interfaces in rgb_hls_if.sv.
module testbench;
    import rgb_hls_pkg::*;

    localparam int LONG_HOLD      = 80;
    localparam int SETTLE_CYCLES  = 30;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [COMP_W-1:0] max_c;
        logic [COMP_W-1:0] min_c;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [LIGHT_W-1:0] light;
        logic [SAT_W-1:0]   sat;
    } t_hls;

    typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_READY, PERIODIC} t_stall_mode;

    logic clk = 1'b0;
    logic rst_n;

    rgb_hls_pix_if pix_ch ();
    rgb_hls_res_if res_ch ();
    rgb_hls_cfg_if cfg_ch ();

    rgb_to_hls_converter_unit dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_ch),
        .i_pixel  (pix_ch),
        .o_result (res_ch)
    );

    t_hls        pending_hls [$];
    int          error_count   = 0;
    bit          hue_wrap      = 1'b1;
    bit          bursty        = 1'b1;
    int          burst_left    = 0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          hold_left     = 0;
    t_stall_mode stall_mode    = ALWAYS_READY;
    int          mode_cycles   = 0;
    int          stall_phase   = 0;
    int          stall_cycles  = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint div_nearest(longint num, longint den);
        longint n2;
        longint d2;
        longint q;
        n2 = 2 * num + den;
        d2 = 2 * den;
        q  = n2 / d2;
        if ((n2 % d2) != 0 && n2 < 0) q -= 1;
        return q;
    endfunction

    function automatic t_hls convert_to_hls(t_pixel p, bit wrap_negative);
        longint r, g, b, mx, mn, span, total, den, hue, sat;
        t_hls   o;
        r   = longint'(p.red);
        g   = longint'(p.green);
        b   = longint'(p.blue);
        mx  = longint'(p.max_c);
        mn  = longint'(p.min_c);
        hue = 0;
        sat = 0;
        o   = '0;
        if (mx != 0) begin
            span    = mx - mn;
            total   = mx + mn;
            o.light = LIGHT_W'(total >> 1);
            if (span > 0) begin
                if (mx == r) hue = div_nearest(DEG_60 * (g - b), span);
                else if (mx == g) hue = div_nearest(DEG_60 * (b - r), span) + DEG_120;
                else if (mx == b) hue = div_nearest(DEG_60 * (r - g), span) + DEG_240;
                den = (total < FULL_SCALE) ? total : 2 * FULL_SCALE - total;
                sat = div_nearest(span * FULL_SCALE, den);
                if (sat > FULL_SCALE) sat = FULL_SCALE;
            end
            if (wrap_negative && hue < 0) hue += DEG_360;
            if (hue < -DEG_60) hue = -DEG_60;
            if (hue > DEG_360) hue = DEG_360;
        end
        o.hue = HUE_W'(hue);
        o.sat = SAT_W'(sat);
        return o;
    endfunction

    function automatic t_pixel make_pixel(int r, int g, int b, int mx, int mn);
        t_pixel p;
        p = '{red: COMP_W'(r), green: COMP_W'(g), blue: COMP_W'(b),
              max_c: COMP_W'(mx), min_c: COMP_W'(mn)};
        return p;
    endfunction

    function automatic t_pixel random_pixel();
        logic [COMP_W-1:0] c [3];
        logic [COMP_W-1:0] base, hi, lo;
        int                shape;
        base = COMP_W'($urandom);
        for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 7))
                0: c[i] = '0;
                1: c[i] = '1;
                2: c[i] = base;
                3: c[i] = base + COMP_W'($urandom_range(0, 3));
                default: c[i] = COMP_W'($urandom);
            endcase
        end
        hi = c[0];
        lo = c[0];
        for (int i = 1; i < 3; i++) begin
            if (c[i] > hi) hi = c[i];
            if (c[i] < lo) lo = c[i];
        end
        shape = $urandom_range(0, 99);
        if (shape < 88) begin
            return make_pixel(c[0], c[1], c[2], hi, lo);
        end else if (shape < 92) begin
            return make_pixel(c[0], c[1], c[2], lo, hi);
        end else if (shape < 96) begin
            return make_pixel(c[0], c[1], c[2], $urandom, $urandom);
        end else begin
            return make_pixel(c[0], c[1], c[2], hi ^ COMP_W'($urandom_range(1, 255)), lo);
        end
    endfunction

    task automatic report_field(string field, int want, int got);
        error_count++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk) begin : result_check
        t_hls want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_hls.size() == 0) begin
                error_count++;
                $display("%0t ns: unexpected result, expected none, actual hue %0d",
                         $time, res_ch.hue);
            end else begin
                want = pending_hls.pop_front();
                if (res_ch.hue !== want.hue)
                    report_field("hue", int'($signed(want.hue)), int'(res_ch.hue));
                if (res_ch.lightness !== want.light)
                    report_field("lightness", int'(want.light), int'(res_ch.lightness));
                if (res_ch.saturation !== want.sat)
                    report_field("saturation", int'(want.sat), int'(res_ch.saturation));
            end
        end
    end

    always @(posedge clk) begin
        stall_phase <= (stall_phase + 1) % 7;
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served  <= hold_requests;
            hold_left    <= LONG_HOLD;
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            if (mode_cycles == 0) begin
                stall_mode  <= t_stall_mode'($urandom_range(0, 3));
                mode_cycles <= $urandom_range(50, 300);
            end else begin
                mode_cycles <= mode_cycles - 1;
            end
            case (stall_mode)
                ALWAYS_READY: res_ch.ready <= 1'b1;
                COIN_FLIP:    res_ch.ready <= 1'($urandom_range(0, 1));
                MOSTLY_READY: res_ch.ready <= ($urandom_range(0, 3) != 0);
                default:      res_ch.ready <= (stall_phase < 4);
            endcase
        end
    end

    always @(posedge clk) begin
        if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_pixel(input t_pixel p);
        pix_ch.valid         <= 1'b1;
        pix_ch.red           <= p.red;
        pix_ch.green         <= p.green;
        pix_ch.blue          <= p.blue;
        pix_ch.max_component <= p.max_c;
        pix_ch.min_component <= p.min_c;
        @(posedge clk);
        while (!pix_ch.ready) @(posedge clk);
        pending_hls.push_back(convert_to_hls(p, hue_wrap));
        if (bursty) begin
            if (burst_left == 0) begin
                pix_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                burst_left = $urandom_range(1, 40);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_hls.size() != 0);
    endtask

    task automatic write_hue_wrap(input bit value);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.normalize_hue <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        hue_wrap = value;
    endtask

    task automatic test_directed_corners();
        send_pixel(make_pixel(0, 0, 0, 0, 0));
        send_pixel(make_pixel('h1234, 'h5678, 'hFFFF, 0, 0));
        send_pixel(make_pixel('h8000, 'h8000, 'h8000, 'h8000, 'h8000));
        send_pixel(make_pixel('hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF));
        send_pixel(make_pixel('hFFFF, 0, 0, 'hFFFF, 0));
        send_pixel(make_pixel(0, 'hFFFF, 0, 'hFFFF, 0));
        send_pixel(make_pixel(0, 0, 'hFFFF, 'hFFFF, 0));
        send_pixel(make_pixel('hC000, 'h4000, 'h8000, 'hC000, 'h4000));
        send_pixel(make_pixel('h3FFF, 'hC000, 'h8000, 'hC000, 'h3FFF));
        send_pixel(make_pixel('h1000, 'h2000, 'h3000, 'h1000, 'h3000));
        send_pixel(make_pixel(1, 2, 3, 'h9000, 1));
        send_pixel(make_pixel(100, 'hFFFF, 0, 100, 99));
        send_pixel(make_pixel('h2000, 'h6000, 'hA000, 'hA000, 'h2000));
        send_pixel(make_pixel('h8000, 'hFFFF, 0, 'hFFFF, 0));
        drain_results();
    endtask

    task automatic test_hue_wrap();
        send_pixel(make_pixel('hFFFF, 0, 'h8000, 'hFFFF, 0));
        send_pixel(make_pixel(100, 0, 'hFFFF, 100, 99));
        send_pixel(make_pixel(7681, 2, 1, 7681, 1));
        send_pixel(make_pixel(7681, 1, 2, 7681, 1));
        drain_results();
        write_hue_wrap(1'b0);
        send_pixel(make_pixel('hFFFF, 0, 'h8000, 'hFFFF, 0));
        send_pixel(make_pixel(100, 0, 'hFFFF, 100, 99));
        send_pixel(make_pixel(7681, 1, 2, 7681, 1));
        drain_results();
        write_hue_wrap(1'b1);
        send_pixel(make_pixel('hFFFF, 0, 'h8000, 'hFFFF, 0));
        drain_results();
    endtask

    task automatic test_random(input int count, input bit wrap);
        write_hue_wrap(wrap);
        repeat (count) send_pixel(random_pixel());
        drain_results();
    endtask

    // The output is held off while requests keep coming, so the block fills and
    // stalls its input; the sender then waits for every outstanding result.
    task automatic test_back_pressure();
        bursty = 1'b0;
        hold_requests++;
        repeat (80) send_pixel(random_pixel());
        bursty = 1'b1;
        drain_results();
    endtask

    initial begin
        rst_n                <= 1'b0;
        pix_ch.valid         <= 1'b0;
        pix_ch.red           <= '0;
        pix_ch.green         <= '0;
        pix_ch.blue          <= '0;
        pix_ch.max_component <= '0;
        pix_ch.min_component <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.normalize_hue <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_hue_wrap();
        test_random(600, 1'b0);
        test_back_pressure();
        test_random(600, 1'b1);
        test_random(450, 1'b0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
